// ===== hdl/pct_pkg.sv =====
// prescaled core timer: shared types and constants
// word layouts for the request and result channels, request and register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_READ    = 2'd2,
    REQ_SERVICE = 2'd3
  } pct_req_e;

  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_PERIOD  = 2'd1,
    REG_SCALE   = 2'd2,
    REG_COUNT   = 2'd3
  } pct_reg_e;

  // interrupt group level owned by the timer
  localparam logic [3:0] TMR_LEVEL = 4'd6;

  // control register bit positions
  localparam int unsigned CTRL_POWER   = 0;
  localparam int unsigned CTRL_ENABLE  = 1;
  localparam int unsigned CTRL_RELOAD  = 2;
  localparam int unsigned CTRL_PENDING = 3;

  typedef struct packed {
    pct_req_e    req_type;
    pct_reg_e    reg_index;
    logic [31:0] write_data;
    logic [3:0]  serviced_level;
  } pct_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        expired;
  } pct_out_t;

endpackage

`default_nettype wire

// ===== hdl/prescaled_core_timer_top.sv =====
// prescaled core timer: top level
// request register, timer core and result register; depends on pct_pkg, pct_in_stage, pct_core and pct_out_stage
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-------------------------------
//   request | in        | in_valid_i / in_stall_o| in_word_i  (pct_in_t)
//   result  | out       | out_valid_o/ out_stall_i| out_word_o (pct_out_t)
//
// one word in per cycle while the result side does not stall, one result word out per request word
// path: request register, then timer update into result register
// the timer state updates when a word moves from the request register to the
// result register, so requests take effect strictly in order
// reset clears all timer registers and both stage valids
// a stall on the result side backs up through the request register to in_stall_o
`timescale 1ns / 1ps
`default_nettype none

module prescaled_core_timer_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pct_pkg::pct_in_t  in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pct_pkg::pct_out_t      out_word_o
);
  import pct_pkg::*;

  // request held between the two registers
  logic     held_valid;
  pct_in_t  held_word;
  // timer update happens on this strobe
  logic     advance;
  pct_out_t result;

  pct_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_word_o  (held_word)
  );

  pct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (held_word),
    .result_o (result)
  );

  pct_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .held_valid_i (held_valid),
    .result_i     (result),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

`default_nettype wire

// ===== hdl/pct_in_stage.sv =====
// prescaled core timer: request register stage
// depends on pct_pkg
`timescale 1ns / 1ps
`default_nettype none

module pct_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire pct_pkg::pct_in_t in_word_i,
  input  wire logic            advance_i,
  output logic                 held_valid_o,
  output pct_pkg::pct_in_t     held_word_o
);
  import pct_pkg::*;

  logic    valid_q;
  logic    valid_d;
  pct_in_t word_q;
  logic    take;

  // stall only while a held word cannot move on
  assign in_stall_o = valid_q & ~advance_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= in_word_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_word_o  = word_q;

endmodule

`default_nettype wire

// ===== hdl/pct_core.sv =====
// prescaled core timer: register file, prescaler and down counter
// depends on pct_pkg
`timescale 1ns / 1ps
`default_nettype none

module pct_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire pct_pkg::pct_in_t item_i,
  output pct_pkg::pct_out_t     result_o
);
  import pct_pkg::*;

  logic        power_q, power_d;
  logic        enable_q, enable_d;
  logic        reload_q, reload_d;
  logic        pending_q, pending_d;
  logic [31:0] period_q, period_d;
  logic [7:0]  scale_q, scale_d;
  logic [31:0] count_q, count_d;
  logic [7:0]  psc_q, psc_d;
  logic [31:0] count_dec;
  logic [31:0] rd;
  logic        expired;

  assign count_dec = count_q - 32'd1;

  always_comb begin
    power_d   = power_q;
    enable_d  = enable_q;
    reload_d  = reload_q;
    pending_d = pending_q;
    period_d  = period_q;
    scale_d   = scale_q;
    count_d   = count_q;
    psc_d     = psc_q;
    rd        = '0;
    expired   = 1'b0;

    case (item_i.req_type)
      REQ_TICK: begin
        if (power_q && enable_q && (count_q != '0)) begin
          if (psc_q < scale_q) begin
            psc_d = psc_q + 8'd1;
          end else begin
            psc_d = '0;
            if (count_dec != '0) begin
              count_d = count_dec;
            end else begin
              // count hit zero: flag it, then reload or stop
              expired   = 1'b1;
              pending_d = 1'b1;
              if (reload_q) begin
                count_d = period_q;
              end else begin
                count_d  = '0;
                enable_d = 1'b0;
              end
            end
          end
        end
      end
      REQ_WRITE: begin
        case (item_i.reg_index)
          REG_CONTROL: begin
            power_d   = item_i.write_data[CTRL_POWER];
            enable_d  = item_i.write_data[CTRL_ENABLE];
            reload_d  = item_i.write_data[CTRL_RELOAD];
            pending_d = item_i.write_data[CTRL_PENDING];
            if (item_i.write_data[CTRL_ENABLE]) begin
              psc_d = '0;
            end
          end
          REG_PERIOD: begin
            period_d = item_i.write_data;
            count_d  = item_i.write_data;
          end
          REG_SCALE: scale_d = item_i.write_data[7:0];
          REG_COUNT: count_d = item_i.write_data;
          default:   count_d = count_q;
        endcase
      end
      REQ_READ: begin
        case (item_i.reg_index)
          REG_CONTROL: rd = {28'd0, pending_q, reload_q, enable_q, power_q};
          REG_PERIOD:  rd = period_q;
          REG_SCALE:   rd = {24'd0, scale_q};
          REG_COUNT:   rd = count_q;
          default:     rd = '0;
        endcase
      end
      REQ_SERVICE: begin
        if (item_i.serviced_level == TMR_LEVEL) begin
          pending_d = 1'b0;
        end
      end
      default: rd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q   <= 1'b0;
      enable_q  <= 1'b0;
      reload_q  <= 1'b0;
      pending_q <= 1'b0;
      period_q  <= '0;
      scale_q   <= '0;
      count_q   <= '0;
      psc_q     <= '0;
    end else if (step_i) begin
      power_q   <= power_d;
      enable_q  <= enable_d;
      reload_q  <= reload_d;
      pending_q <= pending_d;
      period_q  <= period_d;
      scale_q   <= scale_d;
      count_q   <= count_d;
      psc_q     <= psc_d;
    end
  end

  assign result_o.read_data = rd;
  assign result_o.irq_line  = power_d & enable_d & pending_d;
  assign result_o.expired   = expired;

endmodule

`default_nettype wire

// ===== hdl/pct_out_stage.sv =====
// prescaled core timer: result register stage
// depends on pct_pkg
`timescale 1ns / 1ps
`default_nettype none

module pct_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              held_valid_i,
  input  wire pct_pkg::pct_out_t result_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pct_pkg::pct_out_t      out_word_o
);
  import pct_pkg::*;

  logic     valid_q;
  logic     valid_d;
  pct_out_t word_q;
  logic     room;

  // the result register frees up when empty or when its word is taken
  assign room      = ~valid_q | ~out_stall_i;
  assign advance_o = held_valid_i & room;

  always_comb begin
    valid_d = valid_q;
    if (room) begin
      valid_d = held_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      word_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ===== verif/prescaled_core_timer_checker.sv =====
`timescale 1ns / 1ps
// prescaled core timer checker: watches both channels, predicts each result word, compares
// depends on pct_pkg

module prescaled_core_timer_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  pct_pkg::pct_in_t  in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  pct_pkg::pct_out_t out_word_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       due_count_o
);
  import pct_pkg::*;

  // predicted timer registers
  logic        ctl_power;
  logic        ctl_enable;
  logic        ctl_reload;
  logic        ctl_pending;
  logic [31:0] period_q;
  logic [7:0]  scale_q;
  logic [31:0] count_q;
  logic [7:0]  presc_cnt_q;

  pct_out_t    due_results[$];
  int unsigned mismatch_total;

  function automatic logic [31:0] timer_reg_value(input pct_reg_e sel);
    logic [31:0] v;
    v = '0;
    case (sel)
      REG_CONTROL: begin
        v[CTRL_POWER]   = ctl_power;
        v[CTRL_ENABLE]  = ctl_enable;
        v[CTRL_RELOAD]  = ctl_reload;
        v[CTRL_PENDING] = ctl_pending;
      end
      REG_PERIOD: v = period_q;
      REG_SCALE:  v = {24'd0, scale_q};
      default:    v = count_q;
    endcase
    return v;
  endfunction

  // advances the predicted timer by one request word and returns its result word
  function automatic pct_out_t timer_step(input pct_in_t w);
    pct_out_t r;
    r = '0;
    case (w.req_type)
      REQ_TICK: begin
        if (ctl_power && ctl_enable && count_q != 32'd0) begin
          if (presc_cnt_q < scale_q) begin
            presc_cnt_q = presc_cnt_q + 8'd1;
          end else begin
            presc_cnt_q = 8'd0;
            count_q     = count_q - 32'd1;
            if (count_q == 32'd0) begin
              ctl_pending = 1'b1;
              if (ctl_reload) count_q = period_q;
              else ctl_enable = 1'b0;
              r.expired = 1'b1;
            end
          end
        end
      end
      REQ_WRITE: begin
        case (w.reg_index)
          REG_CONTROL: begin
            ctl_power   = w.write_data[CTRL_POWER];
            ctl_enable  = w.write_data[CTRL_ENABLE];
            ctl_reload  = w.write_data[CTRL_RELOAD];
            ctl_pending = w.write_data[CTRL_PENDING];
            if (ctl_enable) presc_cnt_q = 8'd0;
          end
          REG_PERIOD: begin
            period_q = w.write_data;
            count_q  = w.write_data;
          end
          REG_SCALE: scale_q = w.write_data[7:0];
          default:   count_q = w.write_data;
        endcase
      end
      REQ_READ: r.read_data = timer_reg_value(w.reg_index);
      default: begin
        if (w.serviced_level == TMR_LEVEL) ctl_pending = 1'b0;
      end
    endcase
    r.irq_line = ctl_power & ctl_enable & ctl_pending;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pct_out_t want;
    if (!rst_ni) begin
      ctl_power        = 1'b0;
      ctl_enable       = 1'b0;
      ctl_reload       = 1'b0;
      ctl_pending      = 1'b0;
      period_q         = '0;
      scale_q          = '0;
      count_q          = '0;
      presc_cnt_q      = '0;
      mismatch_total   = 0;
      due_results.delete();
      mismatch_count_o <= 0;
      due_count_o      <= 0;
    end else begin
      // result side first: a word accepted now belongs to an older request
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          mismatch_total++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word_i);
        end else begin
          want = due_results.pop_front();
          if (out_word_i.read_data !== want.read_data) begin
            mismatch_total++;
            $display("%0t: read_data expected %h actual %h", $time,
                     want.read_data, out_word_i.read_data);
          end
          if (out_word_i.irq_line !== want.irq_line) begin
            mismatch_total++;
            $display("%0t: irq_line expected %b actual %b", $time,
                     want.irq_line, out_word_i.irq_line);
          end
          if (out_word_i.expired !== want.expired) begin
            mismatch_total++;
            $display("%0t: expired expected %b actual %b", $time,
                     want.expired, out_word_i.expired);
          end
        end
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(timer_step(in_word_i));
      mismatch_count_o <= mismatch_total;
      due_count_o      <= due_results.size();
    end
  end

endmodule

// ===== verif/tb_prescaled_core_timer_top.sv =====
`timescale 1ns / 1ps
// testbench top for the prescaled core timer: clock, reset, request stimulus and verdict
// depends on pct_pkg, prescaled_core_timer_top and prescaled_core_timer_checker

module tb_prescaled_core_timer_top;
  import pct_pkg::*;

  localparam int unsigned IDLE_PCT       = 6;
  localparam int unsigned RANDOM_WORDS   = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  // words sent inside this window go through with no idling on either side
  localparam int unsigned STEADY_FIRST   = 600;
  localparam int unsigned STEADY_LAST    = 900;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  pct_in_t     in_word_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  pct_out_t    out_word_o;

  int unsigned mismatches;
  int unsigned results_due;
  int unsigned words_sent  = 0;
  int unsigned quiet_cycles = 0;
  logic        steady;

  assign steady = (words_sent >= STEADY_FIRST) && (words_sent < STEADY_LAST);

  always #5 clk_i = ~clk_i;

  prescaled_core_timer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  prescaled_core_timer_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_word_i        (in_word_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_word_i       (out_word_o),
    .mismatch_count_o (mismatches),
    .due_count_o      (results_due)
  );

  // result side back-pressure, random except in the steady window
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog: cycles without any word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic pct_in_t make_req(input pct_req_e kind, input pct_reg_e sel,
                                       input logic [31:0] data, input logic [3:0] level);
    pct_in_t w;
    w.req_type       = kind;
    w.reg_index      = sel;
    w.write_data     = data;
    w.serviced_level = level;
    return w;
  endfunction

  // offers one request word, with random idle cycles ahead of it, until accepted
  task automatic send_word(input pct_in_t w);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic write_reg(input pct_reg_e sel, input logic [31:0] data);
    send_word(make_req(REQ_WRITE, sel, data, 4'($urandom)));
  endtask

  task automatic read_reg(input pct_reg_e sel);
    send_word(make_req(REQ_READ, sel, $urandom, 4'($urandom)));
  endtask

  task automatic tick_timer();
    send_word(make_req(REQ_TICK, pct_reg_e'($urandom_range(3)), $urandom, 4'($urandom)));
  endtask

  task automatic service_level(input logic [3:0] level);
    send_word(make_req(REQ_SERVICE, pct_reg_e'($urandom_range(3)), $urandom, level));
  endtask

  // sender holds off until every outstanding result word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  // program scale, period and control, then a burst of mostly ticks
  task automatic run_timer_sequence();
    int unsigned burst;
    logic [3:0]  ctl_bits;
    logic [7:0]  scale_val;
    logic [31:0] period_val;
    ctl_bits = 4'($urandom);
    // mostly a running timer, sometimes powered down or disabled
    if ($urandom_range(9) < 8) begin
      ctl_bits[CTRL_POWER]  = 1'b1;
      ctl_bits[CTRL_ENABLE] = 1'b1;
    end
    // long prescales only now and then, they stretch the expiry a lot
    scale_val  = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
    period_val = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(8, 1));
    write_reg(REG_SCALE, {24'($urandom), scale_val});
    write_reg(REG_PERIOD, period_val);
    write_reg(REG_CONTROL, {28'($urandom), ctl_bits});
    burst = $urandom_range(40, 5);
    repeat (burst) begin
      case ($urandom_range(19))
        0, 1:    read_reg(pct_reg_e'($urandom_range(3)));
        2:       service_level($urandom_range(1) ? TMR_LEVEL : 4'($urandom));
        3:       write_reg(REG_COUNT, 32'($urandom_range(4, 1)));
        default: tick_timer();
      endcase
    end
  endtask

  initial begin
    int unsigned directed_words;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register values straight after reset
    read_reg(REG_CONTROL);
    read_reg(REG_PERIOD);
    read_reg(REG_SCALE);
    read_reg(REG_COUNT);
    // scale keeps only its low byte
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    read_reg(REG_SCALE);
    write_reg(REG_SCALE, 32'h0000_0100);
    // period write loads the count, tick while unpowered does nothing
    write_reg(REG_PERIOD, 32'd2);
    tick_timer();
    // control write sets power, enable and pending, upper bits ignored
    write_reg(REG_CONTROL, 32'hFFFF_FFFB);
    read_reg(REG_CONTROL);
    // only the timer's own level clears pending
    service_level(4'd5);
    service_level(4'd15);
    service_level(TMR_LEVEL);
    // one-shot expiry clears enable, further ticks do nothing
    tick_timer();
    tick_timer();
    tick_timer();
    read_reg(REG_CONTROL);
    // zero period with reload: count stays at zero after the reload
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_CONTROL, 32'h0000_0007);
    tick_timer();
    write_reg(REG_COUNT, 32'd1);
    tick_timer();
    read_reg(REG_COUNT);
    // widest period and a prescale of one
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_SCALE, 32'd1);
    tick_timer();
    tick_timer();
    read_reg(REG_COUNT);
    directed_words = words_sent;

    wait_drained();

    while (words_sent < directed_words + RANDOM_WORDS) begin
      if ($urandom_range(4) == 0) begin
        // noise: any request, any register, any data
        repeat ($urandom_range(4, 1)) begin
          send_word(make_req(pct_req_e'($urandom_range(3)), pct_reg_e'($urandom_range(3)),
                             $urandom, 4'($urandom)));
        end
      end else begin
        run_timer_sequence();
      end
      if ($urandom_range(39) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
